// ===== rtl/core/quadratic_probe_hash_table_defines.svh =====
// Assertion macros for the quadratic probe hash table.
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property at each rising edge, idle while reset is asserted.
`define QPHT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at each rising edge, reset included.
`define QPHT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define QPHT_ASSERT(label, clk, rst_n, prop, msg)

`define QPHT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/core/qpht_pkg.sv =====
// Types and constants of the quadratic probe hash table.
package qpht_pkg;

    localparam int TABLE_SIZE_W = 11;
    localparam int KEY_W        = 31;
    localparam int SLOT_W       = 10;
    localparam int PROBE_W      = 11;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;

    localparam int DEPTH_DEFAULT = 1024;
    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1024;

    // Key remainder: key padded to 32 bits, four bits per cycle.
    localparam int KEY_PAD_W  = 32;
    localparam int MOD_BITS   = 4;
    localparam int MOD_STEPS  = KEY_PAD_W / MOD_BITS;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_SEARCH  = 2'd1,
        OP_DELETE  = 2'd2,
        OP_INVALID = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_MISS  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_USED    = 2'd1,
        SLOT_DELETED = 2'd2
    } t_slot_st;

    typedef struct packed {
        t_slot_st         st;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PROBE
    } t_state;

endpackage

// ===== rtl/core/quadratic_probe_hash_table.sv =====
// Quadratic probe hash table: one slot memory, key remainder unit and probe sequencer.
//
// After reset the block sweeps the slot memory to empty, one entry a cycle; busy stays
// high throughout and configuration writes are taken as ever.
// An operation is accepted when start is high and busy is low. Delete and an invalid
// opcode finish at once: busy stays low and the result beat appears in the cycle after
// the accept, so deletes may follow one another every cycle. Insert and search first
// reduce the key modulo the table size in the remainder unit, four key bits a cycle,
// then walk the probe sequence one slot per cycle through the memory's single read
// port; busy stays high until the probe sequence ends, and the result beat appears
// in the same cycle that busy falls. The result is marked by o_done, high for exactly
// one cycle; the receiver cannot stall it and must take it then. The table size
// register is written through its own valid/ready channel, which is always ready;
// write it only while the block is idle.
`include "quadratic_probe_hash_table_defines.svh"

module quadratic_probe_hash_table #(
    parameter int DEPTH = qpht_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [qpht_pkg::OP_W-1:0]           i_opcode,
    input  logic [qpht_pkg::KEY_W-1:0]          i_key,
    input  logic [qpht_pkg::SLOT_W-1:0]         i_slot_in,
    // result beat
    output logic                                o_done,
    output logic [qpht_pkg::STATUS_W-1:0]       o_status,
    output logic [qpht_pkg::SLOT_W-1:0]         o_slot_out,
    output logic [qpht_pkg::PROBE_W-1:0]        o_probe_count,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qpht_pkg::TABLE_SIZE_W-1:0]   i_cfg_table_size
);

    // Memory index width, and the width of slot numbers, counts and the modulus.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW + 1 > qpht_pkg::TABLE_SIZE_W) ? AW + 1 : qpht_pkg::TABLE_SIZE_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    qpht_pkg::t_state                      r_state, n_state;
    logic [qpht_pkg::TABLE_SIZE_W-1:0]     r_table_size;
    logic [AW-1:0]                         r_clr_addr, n_clr_addr;
    logic [qpht_pkg::MOD_CNT_W-1:0]        r_mod_cnt, n_mod_cnt;
    logic                                  r_pend_vld, n_pend_vld;
    logic                                  r_done, n_done;

    qpht_pkg::t_op                         r_op, n_op;
    logic [qpht_pkg::KEY_W-1:0]            r_key, n_key;
    logic [qpht_pkg::KEY_PAD_W-1:0]        r_kshift, n_kshift;
    logic [CW-1:0]                         r_rem, n_rem;
    logic [CW-1:0]                         r_q, n_q;
    logic [CW-1:0]                         r_i, n_i;
    logic [CW-1:0]                         r_d, n_d;
    logic [CW-1:0]                         r_pend_q, n_pend_q;
    logic [CW-1:0]                         r_pend_i, n_pend_i;
    qpht_pkg::t_status                     r_status, n_status;
    logic [qpht_pkg::SLOT_W-1:0]           r_slot_out, n_slot_out;
    logic [qpht_pkg::PROBE_W-1:0]          r_probe_count, n_probe_count;

    // Slot memory: status and key of each slot, one read and one write port.
    qpht_pkg::t_entry                      r_mem [DEPTH];
    qpht_pkg::t_entry                      r_rd;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                                  accept;
    logic                                  cfg_wr;
    logic [CW-1:0]                         m_eff;
    logic                                  clr_last;
    logic                                  mod_last;
    logic                                  probe_end;
    logic                                  w_we;
    logic [AW-1:0]                         w_addr;
    qpht_pkg::t_entry                      w_data;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Effective modulus: zero counts as one, saturate at the memory depth.
    always_comb begin
        logic [CW-1:0] ts_ext;
        ts_ext = CW'(r_table_size);
        if (ts_ext == '0) begin
            m_eff = CW'(1);
        end else if (ts_ext > DEPTH_C) begin
            m_eff = DEPTH_C;
        end else begin
            m_eff = ts_ext;
        end
    end

    assign clr_last = (r_clr_addr == CLR_LAST);
    assign mod_last = (r_mod_cnt == qpht_pkg::MOD_CNT_W'(qpht_pkg::MOD_STEPS - 1));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            qpht_pkg::ST_CLEAR: begin
                if (clr_last) n_state = qpht_pkg::ST_IDLE;
            end
            qpht_pkg::ST_IDLE: begin
                if (accept && (i_opcode == qpht_pkg::OP_INSERT ||
                               i_opcode == qpht_pkg::OP_SEARCH)) begin
                    n_state = qpht_pkg::ST_MOD;
                end
            end
            qpht_pkg::ST_MOD: begin
                if (mod_last) n_state = qpht_pkg::ST_PROBE;
            end
            qpht_pkg::ST_PROBE: begin
                if (probe_end) n_state = qpht_pkg::ST_IDLE;
            end
            default: n_state = qpht_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath
    // ------------------------------------------------------------------
    always_comb begin
        logic [CW:0]   t;
        logic [CW-1:0] rem_v;
        logic [CW:0]   s;
        logic [CW:0]   d2;
        logic [CW-1:0] pend_cnt;
        logic [CW-1:0] slot_ext;
        logic          last;
        logic          ok;
        logic          miss;

        busy          = (r_state != qpht_pkg::ST_IDLE);

        n_clr_addr    = r_clr_addr;
        n_mod_cnt     = r_mod_cnt;
        n_pend_vld    = r_pend_vld;
        n_done        = 1'b0;
        n_op          = r_op;
        n_key         = r_key;
        n_kshift      = r_kshift;
        n_rem         = r_rem;
        n_q           = r_q;
        n_i           = r_i;
        n_d           = r_d;
        n_pend_q      = r_pend_q;
        n_pend_i      = r_pend_i;
        n_status      = r_status;
        n_slot_out    = r_slot_out;
        n_probe_count = r_probe_count;

        w_we          = 1'b0;
        w_addr        = r_clr_addr;
        w_data        = '{st: qpht_pkg::SLOT_EMPTY, key: '0};

        // Remainder step: shift in four key bits, subtract the modulus where it fits.
        rem_v = r_rem;
        for (int j = 0; j < qpht_pkg::MOD_BITS; j++) begin
            t = {rem_v, r_kshift[qpht_pkg::KEY_PAD_W-1-j]};
            if (t >= {1'b0, m_eff}) t = t - {1'b0, m_eff};
            rem_v = t[CW-1:0];
        end

        // Probe check on the entry read for the pending slot.
        pend_cnt = r_pend_i + CW'(1);
        last     = (pend_cnt == m_eff);
        ok       = 1'b0;
        miss     = 1'b0;
        if (r_op == qpht_pkg::OP_INSERT) begin
            ok   = (r_rd.st != qpht_pkg::SLOT_USED);
            miss = !ok && last;
        end else begin
            ok   = (r_rd.st == qpht_pkg::SLOT_USED) && (r_rd.key == r_key);
            miss = !ok && ((r_rd.st == qpht_pkg::SLOT_EMPTY) || last);
        end
        probe_end = (r_state == qpht_pkg::ST_PROBE) && r_pend_vld && (ok || miss);

        // Next probe slot and step, both kept below the modulus.
        s  = {1'b0, r_q} + {1'b0, r_d};
        if (s >= {1'b0, m_eff}) s = s - {1'b0, m_eff};
        d2 = {1'b0, r_d} + (CW + 1)'(2);
        if (d2 >= {1'b0, m_eff}) d2 = d2 - {1'b0, m_eff};

        slot_ext = CW'(i_slot_in);

        case (r_state)
            qpht_pkg::ST_CLEAR: begin
                w_we       = 1'b1;
                w_addr     = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
            end
            qpht_pkg::ST_IDLE: begin
                if (accept) begin
                    n_op      = qpht_pkg::t_op'(i_opcode);
                    n_key     = i_key;
                    n_kshift  = {1'b0, i_key};
                    n_rem     = '0;
                    n_mod_cnt = '0;
                    case (qpht_pkg::t_op'(i_opcode))
                        qpht_pkg::OP_DELETE: begin
                            n_done = 1'b1;
                            if (slot_ext < m_eff) begin
                                // Mark the slot deleted whatever it held.
                                w_we          = 1'b1;
                                w_addr        = slot_ext[AW-1:0];
                                w_data        = '{st: qpht_pkg::SLOT_DELETED, key: '0};
                                n_status      = qpht_pkg::STATUS_OK;
                                n_slot_out    = i_slot_in;
                                n_probe_count = qpht_pkg::PROBE_W'(1);
                            end else begin
                                n_status      = qpht_pkg::STATUS_RANGE;
                                n_slot_out    = '0;
                                n_probe_count = '0;
                            end
                        end
                        qpht_pkg::OP_INVALID: begin
                            n_done        = 1'b1;
                            n_status      = qpht_pkg::STATUS_RANGE;
                            n_slot_out    = '0;
                            n_probe_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            qpht_pkg::ST_MOD: begin
                n_rem     = rem_v;
                n_kshift  = r_kshift << qpht_pkg::MOD_BITS;
                n_mod_cnt = r_mod_cnt + qpht_pkg::MOD_CNT_W'(1);
                if (mod_last) begin
                    // First probe at key mod m; first step is 2 mod m.
                    n_q        = rem_v;
                    n_i        = '0;
                    n_d        = (m_eff <= CW'(2)) ? '0 : CW'(2);
                    n_pend_vld = 1'b0;
                end
            end
            qpht_pkg::ST_PROBE: begin
                // Issue the read for the next slot while checking the pending one.
                n_pend_q   = r_q;
                n_pend_i   = r_i;
                n_pend_vld = 1'b1;
                n_q        = s[CW-1:0];
                n_i        = r_i + CW'(1);
                n_d        = (m_eff == CW'(1)) ? '0 : d2[CW-1:0];
                if (probe_end) begin
                    n_done        = 1'b1;
                    n_probe_count = pend_cnt[qpht_pkg::PROBE_W-1:0];
                    if (ok) begin
                        n_status   = qpht_pkg::STATUS_OK;
                        n_slot_out = r_pend_q[qpht_pkg::SLOT_W-1:0];
                        if (r_op == qpht_pkg::OP_INSERT) begin
                            w_we   = 1'b1;
                            w_addr = r_pend_q[AW-1:0];
                            w_data = '{st: qpht_pkg::SLOT_USED, key: r_key};
                        end
                    end else begin
                        n_status   = qpht_pkg::STATUS_MISS;
                        n_slot_out = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= qpht_pkg::ST_CLEAR;
            r_table_size <= qpht_pkg::TABLE_SIZE_RESET;
            r_clr_addr   <= '0;
            r_mod_cnt    <= '0;
            r_pend_vld   <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_mod_cnt  <= n_mod_cnt;
            r_pend_vld <= n_pend_vld;
            r_done     <= n_done;
            if (cfg_wr) r_table_size <= i_cfg_table_size;
        end
    end

    // Payload registers: hold without reset.
    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_key         <= n_key;
        r_kshift      <= n_kshift;
        r_rem         <= n_rem;
        r_q           <= n_q;
        r_i           <= n_i;
        r_d           <= n_d;
        r_pend_q      <= n_pend_q;
        r_pend_i      <= n_pend_i;
        r_status      <= n_status;
        r_slot_out    <= n_slot_out;
        r_probe_count <= n_probe_count;
    end

    // Slot memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_data;
        r_rd <= r_mem[r_q[AW-1:0]];
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot_out    = r_slot_out;
    assign o_probe_count = r_probe_count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `QPHT_ASSERT(a_probe_slot_in_range, i_clk, i_rst_n, (r_state == qpht_pkg::ST_PROBE) |-> (r_q < m_eff && r_d < m_eff), "probe slot or step not below the modulus")
    `QPHT_ASSERT(a_done_has_cause, i_clk, i_rst_n, o_done |-> ($past(r_state) == qpht_pkg::ST_PROBE || $past(accept)), "result beat without an operation")
    `QPHT_ASSERT(a_fail_slot_zero, i_clk, i_rst_n, (o_done && o_status != qpht_pkg::STATUS_OK) |-> (o_slot_out == '0), "failed result carries a slot")
    `QPHT_ASSERT(a_no_write_in_mod, i_clk, i_rst_n, (r_state == qpht_pkg::ST_MOD) |-> !w_we, "slot write during key reduction")
    `QPHT_ASSERT_ALWAYS(a_clear_busy, i_clk, (r_state == qpht_pkg::ST_CLEAR) |-> busy, "not busy during clearing pass")

endmodule
